[hdl/wss_pkg.sv]
// ----------------------------------------------------------------------------
// wss_pkg: shared types and constants for the wildcard signature scanner
// Holds the sizes, mode codes and the word layouts of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package wss_pkg;

    localparam int NUM_SIGS = 16;
    localparam int MAX_LEN  = 32;
    localparam int ADDR_W   = 32;
    localparam int SIG_W    = $clog2(NUM_SIGS);
    localparam int POS_W    = $clog2(MAX_LEN);
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int SCNT_W   = $clog2(NUM_SIGS + 1);

    typedef enum logic [1:0] {
        MODE_LOAD_BYTE = 2'd0,
        MODE_LOAD_SET  = 2'd1,
        MODE_SCAN      = 2'd2,
        MODE_QUERY     = 2'd3
    } mode_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [3:0]         sig_index;
        logic [4:0]         byte_index;
        logic [7:0]         data_byte;
        logic [31:0]        address;
        logic               region_first;
        logic [5:0]         sig_length;
        logic [7:0]         wildcard_value;
        logic signed [15:0] match_offset;
    } in_word_t;

    typedef struct packed {
        logic [15:0] occurrence_count;
        logic [31:0] last_location;
        logic        found_once;
    } out_word_t;

endpackage

`default_nettype wire

[hdl/wss_in_if.sv]
// ----------------------------------------------------------------------------
// wss_in_if: input channel of the wildcard signature scanner
// Valid/ready channel that carries one input word.
// ----------------------------------------------------------------------------
`default_nettype none

interface wss_in_if;
    logic               valid;
    logic               ready;
    wss_pkg::in_word_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/wss_out_if.sv]
// ----------------------------------------------------------------------------
// wss_out_if: result channel of the wildcard signature scanner
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface wss_out_if;
    logic               valid;
    logic               ready;
    wss_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/wildcard_signature_scanner_top.sv]
// ----------------------------------------------------------------------------
// wildcard_signature_scanner_top: byte stream scanner for wildcard signatures
// Loads, scans and queries up to NUM_SIGS signatures with a shared comparator.
// ----------------------------------------------------------------------------
// Load and query words are handled on acceptance; a query result is registered
// and shows in the cycle after acceptance. A scan word holds off the input
// until every signature has been compared: acceptance shifts the window and
// starts the row sweep, then one pattern row per cycle is read from the row
// memory and compared by a single wide comparator. Reset (rst_n low, asynchronous)
// disables all signatures and clears counts, locations, settings and the byte window.
`default_nettype none

module wildcard_signature_scanner_top (
    input  wire logic clk,
    input  wire logic rst_n,
    wss_in_if.sink    in_ch,
    wss_out_if.source out_ch
);
    import wss_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [MAX_LEN-1:0][7:0] pat_mem [NUM_SIGS];
    logic [MAX_LEN-1:0][7:0] row_reg;

    logic [LEN_W-1:0]  len_reg  [NUM_SIGS];
    logic [7:0]        wild_reg [NUM_SIGS];
    logic [15:0]       off_reg  [NUM_SIGS];
    logic [15:0]       cnt_reg  [NUM_SIGS];
    logic [ADDR_W-1:0] loc_reg  [NUM_SIGS];

    logic [MAX_LEN-1:0][7:0] win_reg;
    logic [LEN_W-1:0]        fill_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic [SCNT_W-1:0]       rd_sig_reg;
    logic [SIG_W-1:0]        cmp_sig_reg;
    logic                    cmp_vld_reg;

    logic       out_valid_reg;
    out_word_t  out_data_reg;

    logic       accept;
    logic       rd_busy;
    logic       last_cmp;
    logic [LEN_W-1:0] cur_len;
    logic [7:0]       cur_wild;
    logic             match;
    logic [ADDR_W-1:0] new_loc;
    logic [LEN_W-1:0]  len_sat;

    assign in_ch.ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ch.ready);
    assign accept      = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    assign rd_busy  = (rd_sig_reg != SCNT_W'(NUM_SIGS));
    assign last_cmp = cmp_vld_reg && !rd_busy;
    assign cur_len  = len_reg[cmp_sig_reg];
    assign cur_wild = wild_reg[cmp_sig_reg];
    assign len_sat  = (in_ch.data.sig_length > 6'(MAX_LEN)) ? LEN_W'(MAX_LEN)
                                                             : LEN_W'(in_ch.data.sig_length);

    // Pattern byte k lines up with the byte scanned len-1-k words ago.
    always_comb
    begin
        logic [LEN_W-1:0] widx;
        logic             all_hit;
        all_hit = 1'b1;
        for (int k = 0; k < MAX_LEN; k++)
        begin
            widx = cur_len - LEN_W'(1) - LEN_W'(k);
            if ((LEN_W'(k) < cur_len) && (row_reg[k] != cur_wild)
                && (row_reg[k] != win_reg[widx[POS_W-1:0]]))
            begin
                all_hit = 1'b0;
            end
        end
        match = all_hit && (cur_len != '0) && (cur_len <= fill_reg);
    end

    assign new_loc = addr_reg - ADDR_W'(cur_len) + ADDR_W'(1)
                     + ADDR_W'(signed'(off_reg[cmp_sig_reg]));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_ch.data.mode == MODE_SCAN))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_cmp)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept && (in_ch.data.mode == MODE_LOAD_BYTE))
        begin
            pat_mem[in_ch.data.sig_index][in_ch.data.byte_index] <= in_ch.data.data_byte;
        end
        row_reg <= pat_mem[rd_sig_reg[SIG_W-1:0]];
        if (accept)
        begin
            addr_reg <= in_ch.data.address;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            win_reg       <= '0;
            fill_reg      <= '0;
            rd_sig_reg    <= SCNT_W'(NUM_SIGS);
            cmp_sig_reg   <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            for (int s = 0; s < NUM_SIGS; s++)
            begin
                len_reg[s]  <= '0;
                wild_reg[s] <= '0;
                off_reg[s]  <= '0;
                cnt_reg[s]  <= '0;
                loc_reg[s]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_ch.ready && !(accept && (in_ch.data.mode == MODE_QUERY)))
            begin
                out_valid_reg <= 1'b0;
            end
            cmp_vld_reg <= (state_reg == ST_SCAN) && rd_busy;
            cmp_sig_reg <= rd_sig_reg[SIG_W-1:0];
            if ((state_reg == ST_SCAN) && rd_busy)
            begin
                rd_sig_reg <= rd_sig_reg + SCNT_W'(1);
            end
            if (accept)
            begin
                case (in_ch.data.mode)
                    MODE_LOAD_SET:
                    begin
                        len_reg[in_ch.data.sig_index]  <= len_sat;
                        wild_reg[in_ch.data.sig_index] <= in_ch.data.wildcard_value;
                        off_reg[in_ch.data.sig_index]  <= in_ch.data.match_offset;
                    end
                    MODE_SCAN:
                    begin
                        // A region start empties the window before the new word enters.
                        if (in_ch.data.region_first)
                        begin
                            win_reg  <= {{(MAX_LEN-1)*8{1'b0}}, in_ch.data.data_byte};
                            fill_reg <= LEN_W'(1);
                        end
                        else
                        begin
                            win_reg <= {win_reg[MAX_LEN-2:0], in_ch.data.data_byte};
                            if (fill_reg != LEN_W'(MAX_LEN))
                            begin
                                fill_reg <= fill_reg + LEN_W'(1);
                            end
                        end
                        rd_sig_reg <= '0;
                    end
                    MODE_QUERY:
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg.occurrence_count <= cnt_reg[in_ch.data.sig_index];
                        out_data_reg.last_location    <= loc_reg[in_ch.data.sig_index][31:0];
                        out_data_reg.found_once <= (cnt_reg[in_ch.data.sig_index] == 16'd1);
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmp_vld_reg && match)
            begin
                if (cnt_reg[cmp_sig_reg] != 16'hFFFF)
                begin
                    cnt_reg[cmp_sig_reg] <= cnt_reg[cmp_sig_reg] + 16'd1;
                end
                loc_reg[cmp_sig_reg] <= new_loc;
            end
        end
    end

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> (state_reg == ST_IDLE))
        else $error("input ready outside idle");
    a_scan_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_ch.data.mode == MODE_SCAN)) |=> (state_reg == ST_SCAN))
        else $error("scan word did not start the signature sweep");
    a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_vld_reg |-> (state_reg == ST_SCAN))
        else $error("compare active outside scan");
`endif

endmodule

`default_nettype wire
